/* rtl/lphc_pkg.sv */
// Shared types, constants and helpers for the large-prime hash counter.
// No dependencies; lphc_ifs.sv and the core import this package.
package lphc_pkg;

    localparam int KEY_W        = 32;
    localparam int CNT_W        = 32;
    localparam int IDX_OUT_W    = 12;
    localparam int SHIFT_W      = 5;
    localparam int ENTRIES_DEF  = 4096;
    localparam int BUCKET_BITS_DEF = 12;

    localparam logic [KEY_W-1:0]   HASH_MUL         = 32'd2654435761;
    localparam logic [CNT_W-1:0]   CNT_MAX          = '1;
    localparam logic [SHIFT_W-1:0] BUCKET_SHIFT_RST = 5'd20;

    typedef enum logic [1:0] {
        REQ_INC     = 2'd0,
        REQ_READ    = 2'd1,
        REQ_SET_TAG = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_CLEARED  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_ENTRY,
        S_CLR_RD,
        S_CLR_MUL,
        S_CLR_WR
    } state_t;

    // Count after a request: saturating increment, tag when still zero, else unchanged
    function automatic logic [CNT_W-1:0] next_count(
        input req_type_t        rt,
        input logic [CNT_W-1:0] oldc,
        input logic [CNT_W-1:0] tagv
    );
        logic [CNT_W-1:0] res;
        res = oldc;
        case (rt)
            REQ_INC:     res = (oldc == CNT_MAX) ? oldc : oldc + 1'b1;
            REQ_SET_TAG: res = (oldc == '0) ? tagv : oldc;
            default:     res = oldc;
        endcase
        return res;
    endfunction

endpackage

/* rtl/lphc_ifs.sv */
// Channel interfaces of the large-prime hash counter: request, result, config.
// Depends on lphc_pkg for field types and widths.
interface lphc_req_if import lphc_pkg::*; ();
    logic             valid;
    logic             ready;
    req_type_t        req_type;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] tag;

    modport source (output valid, output req_type, output key, output tag, input ready);
    modport sink   (input valid, input req_type, input key, input tag, output ready);
endinterface

interface lphc_res_if import lphc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [CNT_W-1:0]     old_count;
    logic [CNT_W-1:0]     new_count;
    logic [IDX_OUT_W-1:0] entry_index;

    modport source (output valid, output status, output old_count, output new_count,
                    output entry_index, input ready);
    modport sink   (input valid, input status, input old_count, input new_count,
                    input entry_index, output ready);
endinterface

interface lphc_cfg_if import lphc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SHIFT_W-1:0] bucket_shift;

    modport source (output valid, output bucket_shift, input ready);
    modport sink   (input valid, input bucket_shift, output ready);
endinterface

/* rtl/lphc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lphc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and read port that holds its data until the next read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/large_prime_hash_counter_core.sv */
// Large-prime hash counter: chained hash table of keys with saturating counts.
// Depends on lphc_pkg, the interfaces in lphc_ifs.sv and lphc_ram.
//
// Usage
//   req : one transfer per request (req_type, key, tag); res : one transfer per
//   request (status, old_count, new_count, entry_index); cfg : write of the
//   bucket_shift register, always ready, to be written only while the block idles.
//   The bucket of a key is (key * 2654435761 mod 2^32) >> bucket_shift, low
//   BUCKET_BITS bits. Chains live in a bucket-head RAM and an entry RAM, both
//   with registered read data; requests are handled one at a time.
// Sequence
//   A request is taken in S_IDLE, where its hash product is registered; S_HASH
//   reads the bucket head, S_HEAD checks it, and S_ENTRY walks the chain, one
//   entry RAM read per visited entry; a miss on an empty bucket ends in S_HEAD.
//   Clear visits each used entry through S_CLR_RD (read key), S_CLR_MUL (hash)
//   and S_CLR_WR (write head), then reports.
// Reset
//   After reset the head RAM is swept to zero, one bucket a cycle, over all
//   2^BUCKET_BITS buckets; req is not ready during that sweep.
// Stalls
//   The result waits in an output register; a request finishing while it is
//   still untaken holds its final step until res is ready.
module large_prime_hash_counter_core import lphc_pkg::*; #(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int BUCKET_BITS = BUCKET_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    lphc_cfg_if.sink   cfg,
    lphc_req_if.sink   req,
    lphc_res_if.source res
);

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int BUCKETS = 2 ** BUCKET_BITS;
    localparam logic [IDX_W:0] ENT_LIM = (IDX_W + 1)'(ENTRIES);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] link;
        logic [CNT_W-1:0] count;
    } entry_t;

    // Control state
    state_t                 state_reg, state_next;
    logic [SHIFT_W-1:0]     bucket_shift_reg;
    logic [IDX_W-1:0]       used_reg, used_next;
    logic [BUCKET_BITS-1:0] init_reg, init_next;
    logic                   out_valid_reg;

    // Request working registers
    req_type_t              req_type_reg, req_type_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [CNT_W-1:0]       tag_reg, tag_next;
    logic [KEY_W-1:0]       prod_reg, prod_next;
    logic [BUCKET_BITS-1:0] bucket_reg, bucket_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [IDX_W:0]         steps_reg, steps_next;
    logic [IDX_W:0]         clr_idx_reg, clr_idx_next;

    // Output registers
    status_t                status_reg, status_next;
    logic [CNT_W-1:0]       old_count_reg, old_count_next;
    logic [CNT_W-1:0]       new_count_reg, new_count_next;
    logic [IDX_OUT_W-1:0]   entry_index_reg, entry_index_next;
    logic                   load_out;

    // RAM ports
    logic                   head_we, head_re;
    logic [BUCKET_BITS-1:0] head_waddr, head_raddr;
    logic [IDX_W-1:0]       head_wdata, head_rdata;
    logic                   ent_we, ent_re;
    logic [IDX_W-1:0]       ent_waddr, ent_raddr;
    entry_t                 ent_wdata, ent_rdata;

    // Helpers
    logic                   res_ok;
    logic                   do_miss;
    logic                   table_full;
    logic [IDX_W-1:0]       new_slot;
    logic [KEY_W-1:0]       prod_shifted;
    logic [BUCKET_BITS-1:0] bucket_calc;
    logic [CNT_W-1:0]       hit_count;
    logic [CNT_W-1:0]       ins_count;
    logic [IDX_W-1:0]       out_slot;
    logic [IDX_W+IDX_OUT_W-1:0] slot_ext;

    lphc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .clk     (clk),
        .wr_en   (head_we),
        .wr_addr (head_waddr),
        .wr_data (head_wdata),
        .rd_en   (head_re),
        .rd_addr (head_raddr),
        .rd_data (head_rdata)
    );

    lphc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_we),
        .wr_addr (ent_waddr),
        .wr_data (ent_wdata),
        .rd_en   (ent_re),
        .rd_addr (ent_raddr),
        .rd_data (ent_rdata)
    );

    // Handshakes
    assign cfg.ready       = 1'b1;
    assign req.ready       = (state_reg == S_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.status      = status_reg;
    assign res.old_count   = old_count_reg;
    assign res.new_count   = new_count_reg;
    assign res.entry_index = entry_index_reg;
    assign res_ok          = !out_valid_reg || res.ready;

    // Bucket from the registered hash product
    assign prod_shifted = prod_reg >> bucket_shift_reg;
    assign bucket_calc  = prod_shifted[BUCKET_BITS-1:0];

    // Insert slot and capacity
    assign new_slot   = used_reg + 1'b1;
    assign table_full = ({1'b0, used_reg} + 1'b1) >= ENT_LIM;
    assign hit_count  = next_count(req_type_reg, ent_rdata.count, tag_reg);
    assign ins_count  = next_count(req_type_reg, '0, tag_reg);

    // Slot number fitted to the result field
    assign slot_ext   = {{IDX_OUT_W{1'b0}}, out_slot};

    // Next state, RAM accesses and result
    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        init_next        = init_reg;
        req_type_next    = req_type_reg;
        key_next         = key_reg;
        tag_next         = tag_reg;
        prod_next        = prod_reg;
        bucket_next      = bucket_reg;
        slot_next        = slot_reg;
        steps_next       = steps_reg;
        clr_idx_next     = clr_idx_reg;
        load_out         = 1'b0;
        status_next      = status_reg;
        old_count_next   = '0;
        new_count_next   = '0;
        out_slot         = '0;
        do_miss          = 1'b0;
        head_we          = 1'b0;
        head_waddr       = bucket_reg;
        head_wdata       = '0;
        head_re          = 1'b0;
        head_raddr       = bucket_calc;
        ent_we           = 1'b0;
        ent_waddr        = slot_reg;
        ent_wdata        = ent_rdata;
        ent_re           = 1'b0;
        ent_raddr        = slot_reg;

        unique case (state_reg)
            S_INIT:
            begin
                head_we    = 1'b1;
                head_waddr = init_reg;
                init_next  = init_reg + 1'b1;
                if (init_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_type_next = req.req_type;
                    key_next      = req.key;
                    tag_next      = req.tag;
                    prod_next     = req.key * HASH_MUL;
                    if (req.req_type == REQ_CLEAR)
                    begin
                        clr_idx_next = (IDX_W + 1)'(1);
                        state_next   = S_CLR_RD;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end

            S_HASH:
            begin
                head_re     = 1'b1;
                bucket_next = bucket_calc;
                state_next  = S_HEAD;
            end

            S_HEAD:
            begin
                if (head_rdata == '0)
                begin
                    do_miss = 1'b1;
                end
                else
                begin
                    ent_re     = 1'b1;
                    ent_raddr  = head_rdata;
                    slot_next  = head_rdata;
                    steps_next = '0;
                    state_next = S_ENTRY;
                end
            end

            S_ENTRY:
            begin
                if (ent_rdata.key == key_reg)
                begin
                    // Hit: write back the count and report
                    if (res_ok)
                    begin
                        ent_we          = 1'b1;
                        ent_waddr       = slot_reg;
                        ent_wdata       = ent_rdata;
                        ent_wdata.count = hit_count;
                        load_out        = 1'b1;
                        status_next     = ST_FOUND;
                        old_count_next  = ent_rdata.count;
                        new_count_next  = hit_count;
                        out_slot        = slot_reg;
                        state_next      = S_IDLE;
                    end
                end
                else if (ent_rdata.link == '0 || (steps_reg + 1'b1) >= ENT_LIM)
                begin
                    do_miss = 1'b1;
                end
                else
                begin
                    // Advance along the chain
                    ent_re     = 1'b1;
                    ent_raddr  = ent_rdata.link;
                    slot_next  = ent_rdata.link;
                    steps_next = steps_reg + 1'b1;
                end
            end

            S_CLR_RD:
            begin
                if (clr_idx_reg <= {1'b0, used_reg})
                begin
                    ent_re     = 1'b1;
                    ent_raddr  = clr_idx_reg[IDX_W-1:0];
                    state_next = S_CLR_MUL;
                end
                else if (res_ok)
                begin
                    used_next   = '0;
                    load_out    = 1'b1;
                    status_next = ST_CLEARED;
                    state_next  = S_IDLE;
                end
            end

            S_CLR_MUL:
            begin
                prod_next  = ent_rdata.key * HASH_MUL;
                state_next = S_CLR_WR;
            end

            S_CLR_WR:
            begin
                head_we      = 1'b1;
                head_waddr   = bucket_calc;
                clr_idx_next = clr_idx_reg + 1'b1;
                state_next   = S_CLR_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Key absent: append a new entry at the chain head, or report full
        if (do_miss && res_ok)
        begin
            load_out   = 1'b1;
            state_next = S_IDLE;
            if (table_full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                ent_we          = 1'b1;
                ent_waddr       = new_slot;
                ent_wdata.key   = key_reg;
                ent_wdata.link  = head_rdata;
                ent_wdata.count = ins_count;
                head_we         = 1'b1;
                head_waddr      = bucket_reg;
                head_wdata      = new_slot;
                used_next       = new_slot;
                status_next     = ST_INSERTED;
                new_count_next  = ins_count;
                out_slot        = new_slot;
            end
        end

        entry_index_next = slot_ext[IDX_OUT_W-1:0];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            bucket_shift_reg <= BUCKET_SHIFT_RST;
            used_reg         <= '0;
            init_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            init_reg  <= init_next;
            if (cfg.valid)
            begin
                bucket_shift_reg <= cfg.bucket_shift;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_type_reg <= req_type_next;
        key_reg      <= key_next;
        tag_reg      <= tag_next;
        prod_reg     <= prod_next;
        bucket_reg   <= bucket_next;
        slot_reg     <= slot_next;
        steps_reg    <= steps_next;
        clr_idx_reg  <= clr_idx_next;
        if (load_out)
        begin
            status_reg      <= status_next;
            old_count_reg   <= old_count_next;
            new_count_reg   <= new_count_next;
            entry_index_reg <= entry_index_next;
        end
    end

endmodule
